FILE: rtl/indexed_sequence_store_assert.svh
// ---------------------------------------------------------------------------
// Indexed sequence store assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge outside reset
`define ISS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("indexed sequence store assertion failed");

// same-cycle implication
`define ISS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed sequence store assertion failed");

// next-cycle implication
`define ISS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed sequence store assertion failed");

`else

`define ISS_ASSERT_ALWAYS(label, clk, rst, cond)
`define ISS_ASSERT_IMP(label, clk, rst, ante, cons)
`define ISS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/iss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed sequence store package
// Field widths, opcode and status codes, controller/datapath handshake types.
// ---------------------------------------------------------------------------
package iss_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 64;

   localparam int unsigned OPCODE_W   = 3;
   localparam int unsigned POSITION_W = 6;
   localparam int unsigned SPAN_W     = 7;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned LENGTH_W   = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND      = 3'd0,
      OP_REMOVE_LAST = 3'd1,
      OP_INSERT      = 3'd2,
      OP_ERASE       = 3'd3,
      OP_READ        = 3'd4,
      OP_WRITE       = 3'd5,
      OP_CLEAR       = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_INDEX = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic check;
      logic shift;
      logic access;
      logic fetch_first;
      logic fetch_last;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic do_shift;
      logic moves_zero;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: rtl/iss_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed sequence store channels
// Valid/ready request and response interfaces.
// ---------------------------------------------------------------------------
interface iss_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [iss_pkg::OPCODE_W-1:0]   opcode;
   logic        [iss_pkg::POSITION_W-1:0] position;
   logic        [iss_pkg::SPAN_W-1:0]     span;
   logic signed [iss_pkg::DATA_W-1:0]     data_in;

   modport source (output valid, output opcode, output position, output span,
                   output data_in, input ready);
   modport sink   (input valid, input opcode, input position, input span,
                   input data_in, output ready);
endinterface

interface iss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [iss_pkg::STATUS_W-1:0] status;
   logic signed [iss_pkg::DATA_W-1:0]   read_data;
   logic signed [iss_pkg::DATA_W-1:0]   first_value;
   logic signed [iss_pkg::DATA_W-1:0]   last_value;
   logic        [iss_pkg::LENGTH_W-1:0] length;
   logic                                is_empty;

   modport source (output valid, output status, output read_data,
                   output first_value, output last_value, output length,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input read_data,
                   input first_value, input last_value, input length,
                   input is_empty, output ready);
endinterface

FILE: rtl/iss_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed sequence store controller
// Sequences capture, check, shift, access, fetch and response load.
// ---------------------------------------------------------------------------
module iss_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iss_pkg::sts_type sts,
   output iss_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE        = 7'b0000001,
      S_CHECK       = 7'b0000010,
      S_SHIFT       = 7'b0000100,
      S_ACCESS      = 7'b0001000,
      S_FETCH_FIRST = 7'b0010000,
      S_FETCH_LAST  = 7'b0100000,
      S_DONE        = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.do_shift ? S_SHIFT : S_ACCESS;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.moves_zero) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = S_FETCH_FIRST;
         end
         S_FETCH_FIRST: begin
            cmd.fetch_first = 1'b1;
            state_in        = S_FETCH_LAST;
         end
         S_FETCH_LAST: begin
            cmd.fetch_last = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/iss_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed sequence store datapath
// Element memory, count, opcode check, element shifter and response register.
// ---------------------------------------------------------------------------
`include "indexed_sequence_store_assert.svh"

module iss_datapath #(
   parameter int unsigned CAPACITY = iss_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iss_pkg::cmd_type                      cmd,
   output iss_pkg::sts_type                      sts,
   input  logic        [iss_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic        [iss_pkg::POSITION_W-1:0] req_position,
   input  logic        [iss_pkg::SPAN_W-1:0]     req_span,
   input  logic signed [iss_pkg::DATA_W-1:0]     req_data_in,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic        [iss_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed [iss_pkg::DATA_W-1:0]     rsp_read_data,
   output logic signed [iss_pkg::DATA_W-1:0]     rsp_first_value,
   output logic signed [iss_pkg::DATA_W-1:0]     rsp_last_value,
   output logic        [iss_pkg::LENGTH_W-1:0]   rsp_length,
   output logic                                  rsp_is_empty
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned EW = ((CW > iss_pkg::LENGTH_W) ? CW : iss_pkg::LENGTH_W) + 1;
   localparam int unsigned DW = iss_pkg::DATA_W;

   // element memory
   logic signed [DW-1:0] mem [CAPACITY];
   logic signed [DW-1:0] rdata_ff;
   logic                 mem_we;
   logic        [AW-1:0] mem_waddr;
   logic signed [DW-1:0] mem_wdata;
   logic                 mem_re;
   logic        [AW-1:0] mem_raddr;

   // captured transaction
   iss_pkg::opcode_type              op_ff, op_in;
   logic [iss_pkg::POSITION_W-1:0]   pos_ff, pos_in;
   logic [iss_pkg::SPAN_W-1:0]       span_ff, span_in;
   logic signed [DW-1:0]             data_ff, data_in;

   // check results
   iss_pkg::status_type  status_ff, status_in;
   logic                 up_ff, up_in;
   logic                 wr_en_ff, wr_en_in;
   logic                 rd_en_ff, rd_en_in;
   logic [AW-1:0]        acc_addr_ff, acc_addr_in;
   logic [CW-1:0]        moves_ff, moves_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [CW-1:0]        new_cnt_ff, new_cnt_in;

   // shifter and count
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        wr_idx_ff, wr_idx_in;
   logic [CW-1:0]        count_ff, count_in;

   // result assembly
   logic signed [DW-1:0] rd_val_ff, rd_val_in;
   logic signed [DW-1:0] first_ff, first_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [iss_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic signed [DW-1:0]           rsp_read_ff, rsp_read_in;
   logic signed [DW-1:0]           rsp_first_ff, rsp_first_in;
   logic signed [DW-1:0]           rsp_last_ff, rsp_last_in;
   logic [iss_pkg::LENGTH_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   // decode
   iss_pkg::status_type  chk_status;
   logic                 chk_shift;
   logic                 chk_up;
   logic                 chk_wr;
   logic                 chk_rd;
   logic [AW-1:0]        chk_addr;
   logic [CW-1:0]        chk_moves;
   logic [AW-1:0]        chk_src;
   logic [CW-1:0]        chk_cnt;

   logic [EW-1:0] cnt_e, pos_e, span_e, sum_e;
   logic [EW-1:0] cnt_inc_e, cnt_dec_e, ins_moves_e, ers_moves_e, ers_cnt_e;
   logic [EW-1:0] dest_down_e;
   logic          full, empty;
   logic          moves_zero;
   logic          rsp_busy;

   assign cnt_e       = EW'(count_ff);
   assign pos_e       = EW'(pos_ff);
   assign span_e      = EW'(span_ff);
   assign sum_e       = pos_e + span_e;
   assign cnt_inc_e   = cnt_e + EW'(1);
   assign cnt_dec_e   = cnt_e - EW'(1);
   assign ins_moves_e = cnt_e - pos_e;
   assign ers_moves_e = cnt_e - sum_e;
   assign ers_cnt_e   = cnt_e - span_e;
   assign dest_down_e = EW'(src_ff) - span_e;
   assign full        = (cnt_e >= EW'(CAPACITY));
   assign empty       = (count_ff == '0);
   assign moves_zero  = (moves_ff == '0);
   assign rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign sts.do_shift   = chk_shift;
   assign sts.moves_zero = moves_zero;
   assign sts.rsp_busy   = rsp_busy;

   always_comb begin
      chk_status = iss_pkg::ST_OK;
      chk_shift  = 1'b0;
      chk_up     = 1'b0;
      chk_wr     = 1'b0;
      chk_rd     = 1'b0;
      chk_addr   = '0;
      chk_moves  = '0;
      chk_src    = '0;
      chk_cnt    = count_ff;
      case (op_ff)
         iss_pkg::OP_APPEND: begin
            if (full) begin
               chk_status = iss_pkg::ST_FULL;
            end else begin
               chk_wr   = 1'b1;
               chk_addr = cnt_e[AW-1:0];
               chk_cnt  = cnt_inc_e[CW-1:0];
            end
         end
         iss_pkg::OP_REMOVE_LAST: begin
            if (empty) begin
               chk_status = iss_pkg::ST_EMPTY;
            end else begin
               chk_cnt = cnt_dec_e[CW-1:0];
            end
         end
         iss_pkg::OP_INSERT: begin
            if (full) begin
               chk_status = iss_pkg::ST_FULL;
            end else if (empty) begin
               chk_wr   = 1'b1;
               chk_addr = '0;
               chk_cnt  = CW'(1);
            end else if (pos_e >= cnt_e) begin
               chk_status = iss_pkg::ST_INDEX;
            end else begin
               chk_shift = 1'b1;
               chk_up    = 1'b1;
               chk_moves = ins_moves_e[CW-1:0];
               chk_src   = cnt_dec_e[AW-1:0];
               chk_wr    = 1'b1;
               chk_addr  = pos_e[AW-1:0];
               chk_cnt   = cnt_inc_e[CW-1:0];
            end
         end
         iss_pkg::OP_ERASE: begin
            if (empty) begin
               chk_status = iss_pkg::ST_EMPTY;
            end else if (sum_e > cnt_e) begin
               chk_status = iss_pkg::ST_INDEX;
            end else begin
               chk_shift = (ers_moves_e != '0);
               chk_moves = ers_moves_e[CW-1:0];
               chk_src   = sum_e[AW-1:0];
               chk_cnt   = ers_cnt_e[CW-1:0];
            end
         end
         iss_pkg::OP_READ, iss_pkg::OP_WRITE: begin
            if (empty) begin
               chk_status = iss_pkg::ST_EMPTY;
            end else if (pos_e >= cnt_e) begin
               chk_status = iss_pkg::ST_INDEX;
            end else begin
               chk_rd   = (op_ff == iss_pkg::OP_READ);
               chk_wr   = (op_ff == iss_pkg::OP_WRITE);
               chk_addr = pos_e[AW-1:0];
            end
         end
         iss_pkg::OP_CLEAR: begin
            chk_cnt = '0;
         end
         default: begin
         end
      endcase
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = acc_addr_ff;
      mem_wdata = data_ff;
      mem_re    = 1'b0;
      mem_raddr = src_ff;
      if (cmd.shift && pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_idx_ff;
         mem_wdata = rdata_ff;
      end
      if (cmd.access && wr_en_ff) begin
         mem_we = 1'b1;
      end
      if (cmd.shift && !moves_zero) begin
         mem_re = 1'b1;
      end
      if (cmd.access && rd_en_ff) begin
         mem_re    = 1'b1;
         mem_raddr = acc_addr_ff;
      end
      if (cmd.fetch_first) begin
         mem_re    = 1'b1;
         mem_raddr = '0;
      end
      if (cmd.fetch_last) begin
         mem_re    = 1'b1;
         mem_raddr = cnt_dec_e[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // next-state logic
   always_comb begin
      op_in         = op_ff;
      pos_in        = pos_ff;
      span_in       = span_ff;
      data_in       = data_ff;
      status_in     = status_ff;
      up_in         = up_ff;
      wr_en_in      = wr_en_ff;
      rd_en_in      = rd_en_ff;
      acc_addr_in   = acc_addr_ff;
      moves_in      = moves_ff;
      src_in        = src_ff;
      new_cnt_in    = new_cnt_ff;
      pend_in       = pend_ff;
      wr_idx_in     = wr_idx_ff;
      count_in      = count_ff;
      rd_val_in     = rd_val_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (cmd.capture) begin
         op_in   = iss_pkg::opcode_type'(req_opcode);
         pos_in  = req_position;
         span_in = req_span;
         data_in = req_data_in;
      end

      if (cmd.check) begin
         status_in   = chk_status;
         up_in       = chk_up;
         wr_en_in    = chk_wr;
         rd_en_in    = chk_rd;
         acc_addr_in = chk_addr;
         moves_in    = chk_moves;
         src_in      = chk_src;
         new_cnt_in  = chk_cnt;
         pend_in     = 1'b0;
      end

      // read one source per cycle, write it to its new slot the cycle after
      if (cmd.shift) begin
         if (moves_zero) begin
            pend_in = 1'b0;
         end else begin
            pend_in   = 1'b1;
            moves_in  = moves_ff - CW'(1);
            wr_idx_in = up_ff ? (src_ff + AW'(1)) : dest_down_e[AW-1:0];
            src_in    = up_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
         end
      end

      if (cmd.access) begin
         count_in = new_cnt_ff;
      end

      if (cmd.fetch_first) begin
         rd_val_in = rd_en_ff ? rdata_ff : '0;
      end

      if (cmd.fetch_last) begin
         first_in = rdata_ff;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_read_in   = rd_val_ff;
         rsp_first_in  = empty ? '0 : first_ff;
         rsp_last_in   = empty ? '0 : rdata_ff;
         rsp_len_in    = cnt_e[iss_pkg::LENGTH_W-1:0];
         rsp_empty_in  = empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      span_ff       <= span_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      up_ff         <= up_in;
      wr_en_ff      <= wr_en_in;
      rd_en_ff      <= rd_en_in;
      acc_addr_ff   <= acc_addr_in;
      moves_ff      <= moves_in;
      src_ff        <= src_in;
      new_cnt_ff    <= new_cnt_in;
      wr_idx_ff     <= wr_idx_in;
      rd_val_ff     <= rd_val_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_read_ff;
   assign rsp_first_value = rsp_first_ff;
   assign rsp_last_value  = rsp_last_ff;
   assign rsp_length      = rsp_len_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   `ISS_ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_e <= EW'(CAPACITY))
   `ISS_ASSERT_IMP(a_shift_drained, clock, reset, cmd.access, !pend_ff)
   `ISS_ASSERT_IMP(a_load_free, clock, reset, cmd.load_rsp, !rsp_busy)
   `ISS_ASSERT_NEXT(a_count_commit, clock, reset, !cmd.access, $stable(count_ff))

endmodule

FILE: rtl/indexed_sequence_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed sequence store
// Bounded ordered sequence of signed words with indexed insert and erase.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one operation per transaction: opcode, position, span and
//   data_in. rsp_if returns exactly one result per request: status, read
//   value, first and last elements, length and empty flag.
//   A request is taken only while the block is idle. One that moves no
//   elements passes capture, check, access, first fetch and last fetch,
//   then loads its response and returns to idle for the next request.
//   Insert moves length - position elements, erase range length - position -
//   span, one per cycle through the single memory read port plus a drain
//   step for the last write, before access and the fetches follow.
//   The response sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, a finished operation holds
//   until the register frees, and request acceptance stops meanwhile.
//   Reset empties the sequence at once (length zero, no clearing pass) and
//   drops any pending response; memory contents are left as they are.
// ---------------------------------------------------------------------------
module indexed_sequence_store #(
   parameter int unsigned CAPACITY = iss_pkg::CAPACITY_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   iss_req_if.sink   req_if,
   iss_rsp_if.source rsp_if
);

   iss_pkg::cmd_type cmd;
   iss_pkg::sts_type sts;

   iss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iss_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_if.opcode),
      .req_position    (req_if.position),
      .req_span        (req_if.span),
      .req_data_in     (req_if.data_in),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_read_data   (rsp_if.read_data),
      .rsp_first_value (rsp_if.first_value),
      .rsp_last_value  (rsp_if.last_value),
      .rsp_length      (rsp_if.length),
      .rsp_is_empty    (rsp_if.is_empty)
   );

endmodule
